/* rtl/csms_pkg.sv */
`timescale 1ns / 1ps
// Package for the channel statistics block: widths, action codes, state
// codes, the stored entry and request layouts, and the millivolt scaling.
// No dependencies.
package csms_pkg;

    localparam int NUM_CHANNELS = 8;
    localparam int CH_BITS      = 3;
    localparam int ACTION_BITS  = 3;
    localparam int SAMPLE_BITS  = 10;
    localparam int COUNT_BITS   = 22;
    localparam int TOTAL_BITS   = 32;
    localparam int MV_BITS      = 13;
    localparam int MV_SCALE     = 5000;
    localparam int MV_SHIFT     = 10;
    localparam int PROD_BITS    = SAMPLE_BITS + MV_BITS;
    localparam int STEP_BITS    = $clog2(SAMPLE_BITS + 1);
    localparam int IN_BITS      = 16;
    localparam int OUT_BITS     = 112;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [ACTION_BITS-1:0] {
        ACT_SAMPLE    = 3'd0,
        ACT_START     = 3'd1,
        ACT_STOP      = 3'd2,
        ACT_SHOW      = 3'd3,
        ACT_RESET_ALL = 3'd4
    } action_e;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DIV,
        S_FMT
    } state_e;

    // One channel's stored statistics
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] low;
        logic [SAMPLE_BITS-1:0] high;
        logic [TOTAL_BITS-1:0]  total;
        logic [COUNT_BITS-1:0]  tally;
    } stats_entry_t;

    localparam stats_entry_t ENTRY_RESET = '{
        low:   '1,
        high:  '0,
        total: '0,
        tally: '0
    };

    // Input request, last field in the lowest bits
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic [CH_BITS-1:0]     channel;
        logic [ACTION_BITS-1:0] action;
    } in_req_t;

    // Result, last field in the lowest bits, padded to whole bytes
    typedef struct packed {
        logic [5:0]             pad;
        logic [MV_BITS-1:0]     mean_millivolts;
        logic [MV_BITS-1:0]     max_millivolts;
        logic [MV_BITS-1:0]     min_millivolts;
        logic [SAMPLE_BITS-1:0] spread;
        logic [SAMPLE_BITS-1:0] mean_value;
        logic [SAMPLE_BITS-1:0] max_value;
        logic [SAMPLE_BITS-1:0] min_value;
        logic [COUNT_BITS-1:0]  sample_count;
        logic                   has_data;
        logic                   is_active;
        logic [CH_BITS-1:0]     out_channel;
    } result_t;

    typedef struct packed {
        logic                  start;
        logic [TOTAL_BITS-1:0] dividend;
        logic [COUNT_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                   done;
        logic [SAMPLE_BITS-1:0] quotient;
    } div_rsp_t;

    // value * 5000 / 1024, truncated
    function automatic logic [MV_BITS-1:0] to_mv(input logic [SAMPLE_BITS-1:0] v);
        logic [PROD_BITS-1:0] p;
        p = PROD_BITS'(v) * PROD_BITS'(MV_SCALE);
        return MV_BITS'(p >> MV_SHIFT);
    endfunction

endpackage

/* rtl/csms_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module csms_ram #(
    parameter int WIDTH     = 8,
    parameter int DEPTH     = 8,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/csms_div.sv */
`timescale 1ns / 1ps
// Restoring divider for the channel mean: one quotient bit per cycle.
// Depends on csms_pkg.
module csms_div
    import csms_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [STEP_BITS-1:0]   step_reg, step_next;
    logic [COUNT_BITS-1:0]  rem_reg, rem_next;
    logic [SAMPLE_BITS-1:0] low_reg, low_next;
    logic [SAMPLE_BITS-1:0] quo_reg, quo_next;
    logic [COUNT_BITS-1:0]  dvs_reg, dvs_next;
    logic [COUNT_BITS:0]    trial;
    logic [COUNT_BITS:0]    diff;
    logic                   ge;

    // The mean never exceeds the largest sample, so the bits of the dividend
    // above SAMPLE_BITS form a partial remainder already below the divisor.
    assign trial = {rem_reg, low_reg[SAMPLE_BITS-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = STEP_BITS'(SAMPLE_BITS);
            rem_next  = COUNT_BITS'(req.dividend >> SAMPLE_BITS);
            low_next  = req.dividend[SAMPLE_BITS-1:0];
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
            low_next  = low_reg << 1;
            quo_next  = {quo_reg[SAMPLE_BITS-2:0], ge};
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

`ifndef SYNTHESIS
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider restarted while busy");
`endif

endmodule

/* rtl/channel_min_max_mean_stats_top.sv */
`timescale 1ns / 1ps
// Per-channel minimum / maximum / mean statistics engine, top level.
// Depends on csms_pkg, csms_ram and csms_div.
//
// Usage:
//   Requests arrive on the s_axis channel: action, channel and a 10-bit
//   sample packed in s_axis_tdata. Every request returns exactly one result
//   on m_axis: the addressed channel's count, min, max, mean, spread and the
//   three millivolt values, as they stand after the action.
//   Statistics live in an 8-entry RAM (one entry per channel) with a
//   registered read; each request reads its entry, modifies and writes it
//   back before the next request is taken, so accesses never overlap.
//   The mean comes from a bit-serial divider, one quotient bit per cycle.
// Request flow:
//   A channel holding samples goes from the read state through the
//   divider to the formatting state; a channel with no samples skips the
//   divider and goes from read straight to formatting. The next request
//   is taken only after the result is loaded and the block is idle again.
// Reset:
//   rst_n clears the per-entry valid bits and the active flags at once; an
//   entry not valid reads as cleared (min all ones, the rest zero). Reset-all
//   requests clear them the same way. No clearing pass is needed.
// Back-pressure:
//   The result sits in an output register; the next request is accepted
//   while it waits. A finished result that meets a full, stalled output
//   register holds in the formatting state until m_axis_tready frees it.
module channel_min_max_mean_stats_top
    import csms_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // [2:0] action, [5:3] channel, [15:6] sample
    input  logic [IN_BITS-1:0]  s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // [2:0] out_channel, [3] is_active, [4] has_data, [26:5] sample_count,
    // [36:27] min_value, [46:37] max_value, [56:47] mean_value,
    // [66:57] spread, [79:67] min_millivolts, [92:80] max_millivolts,
    // [105:93] mean_millivolts, [111:106] zero
    output logic [OUT_BITS-1:0] m_axis_tdata
);

    state_e                  state_reg, state_next;
    in_req_t                 in_req;
    logic                    accept;

    action_e                 action_reg;
    logic [CH_BITS-1:0]      ch_reg;
    logic [SAMPLE_BITS-1:0]  smp_reg;

    logic [NUM_CHANNELS-1:0] valid_reg, valid_next;
    logic [NUM_CHANNELS-1:0] active_reg, active_next;

    stats_entry_t            ram_rdata;
    stats_entry_t            cur;
    stats_entry_t            upd;
    logic                    cur_active;
    logic                    upd_active;
    logic                    ram_we;
    logic [TOTAL_BITS:0]     sum_wide;
    logic                    can_count;

    stats_entry_t            stat_reg;
    logic                    stat_active_reg;
    logic [SAMPLE_BITS-1:0]  mean_reg;

    div_req_t                div_req;
    div_rsp_t                div_rsp;

    result_t                 res;
    result_t                 out_res_reg;
    logic                    out_valid_reg, out_valid_next;
    logic                    load;

    assign in_req = in_req_t'(s_axis_tdata);
    assign accept = s_axis_tvalid && s_axis_tready;

    // Hold the accepted request's fields for the read-modify-write
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= action_e'(in_req.action);
            ch_reg     <= in_req.channel;
            smp_reg    <= in_req.sample;
        end
    end

    csms_ram #(
        .WIDTH ($bits(stats_entry_t)),
        .DEPTH (NUM_CHANNELS)
    ) u_stats_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ch_reg),
        .wdata (upd),
        .re    (accept),
        .raddr (in_req.channel),
        .rdata (ram_rdata)
    );

    // Modify: merge the read entry with the action. An entry never written
    // since the last clear reads as the cleared value.
    always_comb
    begin
        if (valid_reg[ch_reg] && action_reg != ACT_RESET_ALL)
        begin
            cur = ram_rdata;
        end
        else
        begin
            cur = ENTRY_RESET;
        end
        cur_active = active_reg[ch_reg] && (action_reg != ACT_RESET_ALL);

        sum_wide  = {1'b0, cur.total} + (TOTAL_BITS + 1)'(smp_reg);
        can_count = (cur.tally != COUNT_MAX) && !sum_wide[TOTAL_BITS];

        upd        = cur;
        upd_active = cur_active;
        ram_we     = 1'b0;
        case (action_reg)
            ACT_SAMPLE:
            begin
                if (cur_active)
                begin
                    if (smp_reg < cur.low)
                    begin
                        upd.low = smp_reg;
                    end
                    if (smp_reg > cur.high)
                    begin
                        upd.high = smp_reg;
                    end
                    // Saturated: hold sum and count, marks still move
                    if (can_count)
                    begin
                        upd.total = sum_wide[TOTAL_BITS-1:0];
                        upd.tally = cur.tally + 1'b1;
                    end
                    ram_we = (state_reg == S_READ);
                end
            end
            ACT_START:
            begin
                upd        = ENTRY_RESET;
                upd_active = 1'b1;
                ram_we     = (state_reg == S_READ);
            end
            ACT_STOP:
            begin
                upd_active = 1'b0;
            end
            default:
            begin
                upd_active = cur_active;
            end
        endcase
    end

    // Valid bits and active flags: reset-all drops every channel at once
    always_comb
    begin
        valid_next  = valid_reg;
        active_next = active_reg;
        if (state_reg == S_READ)
        begin
            if (action_reg == ACT_RESET_ALL)
            begin
                valid_next  = '0;
                active_next = '0;
            end
            else
            begin
                active_next[ch_reg] = upd_active;
                if (ram_we)
                begin
                    valid_next[ch_reg] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            active_reg <= '0;
        end
        else
        begin
            valid_reg  <= valid_next;
            active_reg <= active_next;
        end
    end

    // Keep the updated entry for reporting; latch the mean when it arrives
    always_ff @(posedge clk)
    begin
        if (state_reg == S_READ)
        begin
            stat_reg        <= upd;
            stat_active_reg <= upd_active;
            mean_reg        <= '0;
        end
        else if (state_reg == S_DIV && div_rsp.done)
        begin
            mean_reg <= div_rsp.quotient;
        end
    end

    csms_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = (upd.tally != '0) ? S_DIV : S_FMT;
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_FMT;
                end
            end
            S_FMT:
            begin
                if (load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        s_axis_tready    = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = upd.total;
        div_req.divisor  = upd.tally;
        load             = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            S_READ:
            begin
                div_req.start = (upd.tally != '0);
            end
            S_DIV:
            begin
                load = 1'b0;
            end
            S_FMT:
            begin
                load = !out_valid_reg || m_axis_tready;
            end
            default:
            begin
                load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Format the result; fields other than channel, active flag and count read zero with no data
    always_comb
    begin
        res              = '0;
        res.out_channel  = ch_reg;
        res.is_active    = stat_active_reg;
        res.sample_count = stat_reg.tally;
        if (stat_reg.tally != '0)
        begin
            res.has_data        = 1'b1;
            res.min_value       = stat_reg.low;
            res.max_value       = stat_reg.high;
            res.mean_value      = mean_reg;
            res.spread          = (stat_reg.high >= stat_reg.low) ?
                                  stat_reg.high - stat_reg.low : '0;
            res.min_millivolts  = to_mv(stat_reg.low);
            res.max_millivolts  = to_mv(stat_reg.high);
            res.mean_millivolts = to_mv(mean_reg);
        end
    end

    // Output register: load a new result, drop it once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_res_reg;

`ifndef SYNTHESIS
    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_READ)
        else $error("accepted request did not move to the read state");

    a_write_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> state_reg == S_READ)
        else $error("statistics RAM written outside the read state");

    a_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == S_DIV)
        else $error("divider finished with no request waiting");

    a_mean_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.has_data) |->
            (out_res_reg.mean_value >= out_res_reg.min_value &&
             out_res_reg.mean_value <= out_res_reg.max_value))
        else $error("reported mean lies outside min and max");
`endif

endmodule

/* dv/csms_stats_checker.sv */
`timescale 1ns / 1ps
// Checker for the channel statistics block: watches both stream channels,
// predicts each result from its own copy of the per-channel state and
// compares field by field. Depends on csms_pkg.
module csms_stats_checker
    import csms_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_ready,
    input  logic [IN_BITS-1:0]  req_data,
    input  logic                res_valid,
    input  logic                res_ready,
    input  logic [OUT_BITS-1:0] res_data,
    output int                  fail_count,
    output int                  outstanding
);

    // Predicted per-channel statistics
    logic [SAMPLE_BITS-1:0] chan_low   [NUM_CHANNELS];
    logic [SAMPLE_BITS-1:0] chan_high  [NUM_CHANNELS];
    logic [TOTAL_BITS-1:0]  chan_total [NUM_CHANNELS];
    logic [COUNT_BITS-1:0]  chan_count [NUM_CHANNELS];
    logic                   chan_on    [NUM_CHANNELS];

    result_t stats_due[$];
    int      mismatches = 0;

    function automatic logic [MV_BITS-1:0] millivolts_of(input logic [SAMPLE_BITS-1:0] v);
        logic [31:0] scaled;
        scaled = 32'(v) * 32'(MV_SCALE);
        return MV_BITS'(scaled >> MV_SHIFT);
    endfunction

    task automatic clear_chan(input int c);
        chan_low[c]   = '1;
        chan_high[c]  = '0;
        chan_total[c] = '0;
        chan_count[c] = '0;
    endtask

    // Apply one request to the predicted state and build its result
    task automatic apply_request(input in_req_t req, output result_t res);
        int                     c;
        logic [SAMPLE_BITS-1:0] smp;
        logic [TOTAL_BITS:0]    grown;
        logic [TOTAL_BITS-1:0]  avg;
        c   = int'(req.channel);
        smp = req.sample;
        res = '0;
        res.out_channel = req.channel;
        case (req.action)
            ACT_RESET_ALL:
            begin
                for (int i = 0; i < NUM_CHANNELS; i++)
                begin
                    clear_chan(i);
                    chan_on[i] = 1'b0;
                end
            end
            ACT_SAMPLE:
            begin
                if (chan_on[c])
                begin
                    if (smp < chan_low[c])
                        chan_low[c] = smp;
                    if (smp > chan_high[c])
                        chan_high[c] = smp;
                    // hold total and count once either would overflow
                    grown = {1'b0, chan_total[c]} + (TOTAL_BITS + 1)'(smp);
                    if (chan_count[c] != COUNT_MAX && !grown[TOTAL_BITS])
                    begin
                        chan_total[c] = grown[TOTAL_BITS-1:0];
                        chan_count[c] = chan_count[c] + 1'b1;
                    end
                end
            end
            ACT_START:
            begin
                clear_chan(c);
                chan_on[c] = 1'b1;
            end
            ACT_STOP:
                chan_on[c] = 1'b0;
            default: ;
        endcase
        res.is_active    = chan_on[c];
        res.sample_count = chan_count[c];
        if (chan_count[c] != '0)
        begin
            avg                 = chan_total[c] / TOTAL_BITS'(chan_count[c]);
            res.has_data        = 1'b1;
            res.min_value       = chan_low[c];
            res.max_value       = chan_high[c];
            res.mean_value      = avg[SAMPLE_BITS-1:0];
            res.spread          = (chan_high[c] >= chan_low[c]) ?
                                  chan_high[c] - chan_low[c] : '0;
            res.min_millivolts  = millivolts_of(chan_low[c]);
            res.max_millivolts  = millivolts_of(chan_high[c]);
            res.mean_millivolts = millivolts_of(avg[SAMPLE_BITS-1:0]);
        end
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] seen);
        if (want !== seen)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s expected %0d got %0d", $time, field, want, seen);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        result_t seen;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                clear_chan(i);
                chan_on[i] = 1'b0;
            end
            stats_due.delete();
        end
        else
        begin
            // results first, so a result can never meet its own request
            if (res_valid && res_ready)
            begin
                seen = result_t'(res_data);
                if (stats_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result for channel %0d with no request pending",
                                 $time, seen.out_channel);
                end
                else
                begin
                    want = stats_due.pop_front();
                    check_field("out_channel", 32'(want.out_channel),
                                32'(seen.out_channel));
                    check_field("is_active", 32'(want.is_active),
                                32'(seen.is_active));
                    check_field("has_data", 32'(want.has_data),
                                32'(seen.has_data));
                    check_field("sample_count", 32'(want.sample_count),
                                32'(seen.sample_count));
                    check_field("min_value", 32'(want.min_value),
                                32'(seen.min_value));
                    check_field("max_value", 32'(want.max_value),
                                32'(seen.max_value));
                    check_field("mean_value", 32'(want.mean_value),
                                32'(seen.mean_value));
                    check_field("spread", 32'(want.spread),
                                32'(seen.spread));
                    check_field("min_millivolts", 32'(want.min_millivolts),
                                32'(seen.min_millivolts));
                    check_field("max_millivolts", 32'(want.max_millivolts),
                                32'(seen.max_millivolts));
                    check_field("mean_millivolts", 32'(want.mean_millivolts),
                                32'(seen.mean_millivolts));
                end
            end
            if (req_valid && req_ready)
            begin
                apply_request(in_req_t'(req_data), want);
                stats_due.push_back(want);
            end
        end
        outstanding <= stats_due.size();
        fail_count  <= mismatches;
    end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// Top of the channel statistics testbench: clock, reset, request stimulus,
// result back-pressure and the verdict. Depends on csms_pkg, the block and
// csms_stats_checker.
module tb_top;
    import csms_pkg::*;

    // Actions the block does not define; they must report like a show
    localparam logic [ACTION_BITS-1:0] ACT_SPARE_5 = 3'd5;
    localparam logic [ACTION_BITS-1:0] ACT_SPARE_6 = 3'd6;
    localparam logic [ACTION_BITS-1:0] ACT_SPARE_7 = 3'd7;

    // Random requests to send after the directed part
    localparam int RANDOM_ITEMS = 1900;
    // Worst case per request is the divider path plus stalls; allow far more
    localparam int CYCLE_LIMIT  = 600000;
    // Tail after the last result, to catch stray results
    localparam int SETTLE       = 20;

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [IN_BITS-1:0] s_axis_tdata  = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [OUT_BITS-1:0] m_axis_tdata;

    int                    fails;
    int                    outstanding;
    int                    cycles = 0;
    // Suspend random idling on both sides while set
    bit                    calm   = 1'b0;
    // Channels the stimulus believes are collecting
    logic [NUM_CHANNELS-1:0] live = '0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    channel_min_max_mean_stats_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    csms_stats_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (s_axis_tvalid),
        .req_ready   (s_axis_tready),
        .req_data    (s_axis_tdata),
        .res_valid   (m_axis_tvalid),
        .res_ready   (m_axis_tready),
        .res_data    (m_axis_tdata),
        .fail_count  (fails),
        .outstanding (outstanding)
    );

    // Stall the result side with a chance of about 30 in a hundred, never while calm
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= calm || ($urandom_range(0, 99) >= 30);
    end

    // Watchdog: give up on a hang
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Offer one request, idling at random first, and hold it until taken.
    // Valid stays high into the next request unless that one idles first.
    task automatic send_request(input logic [ACTION_BITS-1:0] act,
                                input logic [CH_BITS-1:0] ch,
                                input logic [SAMPLE_BITS-1:0] smp);
        in_req_t req;
        req.action  = act;
        req.channel = ch;
        req.sample  = smp;
        while (!calm && $urandom_range(0, 99) < 30)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= req;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        case (act)
            ACT_START:     live[ch] = 1'b1;
            ACT_STOP:      live[ch] = 1'b0;
            ACT_RESET_ALL: live     = '0;
            default: ;
        endcase
    endtask

    // Drop valid and hold off until every predicted result has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        int                     done_items;
        int                     pick;
        logic [ACTION_BITS-1:0] act;
        logic [CH_BITS-1:0]     ch;
        logic [SAMPLE_BITS-1:0] smp;

        done_items = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty channels, extremes, ignored samples, stop,
        // undefined actions, reset-all and a restart that clears the stats
        send_request(ACT_SHOW,      3'd0, '0);
        send_request(ACT_SAMPLE,    3'd0, '1);
        send_request(ACT_START,     3'd0, '0);
        send_request(ACT_SHOW,      3'd0, '0);
        send_request(ACT_SAMPLE,    3'd0, '0);
        send_request(ACT_SAMPLE,    3'd0, '1);
        send_request(ACT_SAMPLE,    3'd0, 10'd512);
        send_request(ACT_START,     3'd7, '1);
        send_request(ACT_SAMPLE,    3'd7, '1);
        send_request(ACT_SAMPLE,    3'd7, '1);
        send_request(ACT_STOP,      3'd7, '0);
        send_request(ACT_SAMPLE,    3'd7, 10'd7);
        send_request(ACT_SHOW,      3'd7, '0);
        send_request(ACT_SPARE_5,   3'd3, 10'h2AA);
        send_request(ACT_SPARE_6,   3'd0, 10'h155);
        send_request(ACT_SPARE_7,   3'd7, '1);
        send_request(ACT_START,     3'd3, '0);
        send_request(ACT_SAMPLE,    3'd3, 10'h2AA);
        send_request(ACT_SAMPLE,    3'd3, 10'h155);
        send_request(ACT_RESET_ALL, 3'd2, '1);
        send_request(ACT_SHOW,      3'd0, '0);
        send_request(ACT_SHOW,      3'd3, '0);
        send_request(ACT_START,     3'd5, '0);
        send_request(ACT_SAMPLE,    3'd5, 10'd1);
        send_request(ACT_START,     3'd5, '0);
        drain();

        // Random part: mostly samples aimed at collecting channels, with
        // starts, stops, shows and the odd reset-all or undefined action
        while (done_items < RANDOM_ITEMS)
        begin
            calm = (done_items >= 600 && done_items < 900);
            if (done_items == 1200)
                drain();
            pick = $urandom_range(0, 99);
            if (pick < 68)
                act = ACT_SAMPLE;
            else if (pick < 76)
                act = ACT_START;
            else if (pick < 82)
                act = ACT_STOP;
            else if (pick < 90)
                act = ACT_SHOW;
            else if (pick < 92)
                act = ACT_RESET_ALL;
            else
            begin
                case ($urandom_range(0, 2))
                    0:       act = ACT_SPARE_5;
                    1:       act = ACT_SPARE_6;
                    default: act = ACT_SPARE_7;
                endcase
            end
            ch = CH_BITS'($urandom_range(0, NUM_CHANNELS - 1));
            // steer most samples to a collecting channel
            if (act == ACT_SAMPLE && live != '0 && $urandom_range(0, 99) < 85)
            begin
                while (!live[ch])
                    ch = CH_BITS'($urandom_range(0, NUM_CHANNELS - 1));
            end
            case ($urandom_range(0, 9))
                0:       smp = '0;
                1:       smp = '1;
                default: smp = SAMPLE_BITS'($urandom_range(0, (1 << SAMPLE_BITS) - 1));
            endcase
            send_request(act, ch, smp);
            done_items++;
        end
        calm = 1'b0;

        // Wait out the last results, then a short settle for strays
        drain();
        repeat (SETTLE) @(posedge clk);
        if (fails == 0 && outstanding == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
